@@ hw/rtl/slbs_pkg.sv @@
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types, codes and constant-divider helpers for the status light and
// beeper sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

  localparam int FULL_DUTY_DEF = 1000;

  localparam int NOW_W   = 32;
  localparam int SCALE_W = 7;
  localparam int DUTY_W  = 10;
  localparam int CFG_W   = 2;
  localparam int FULL_W  = 16;   // widest full-scale duty the block supports

  localparam logic [SCALE_W-1:0] PCT_MAX  = 7'd100;
  localparam logic [DUTY_W-1:0]  DUTY_SAT = 10'd1023;

  // floor(n/d) == (n * M) >> K, exact over the operand range
  localparam logic [23:0] M100   = 24'd10737419;    // n < 2^23, K = 30
  localparam int          K100   = 30;
  localparam logic [26:0] M1000  = 27'd68719477;    // n < 2^26, K = 36
  localparam int          K1000  = 36;
  localparam logic [28:0] M375   = 29'd366503876;   // n < 2^28, K = 37
  localparam int          K375   = 37;

  localparam logic [8:0]  LCM_DIV    = 9'd375;      // 6000 / 16
  localparam logic [12:0] BREATHE_P  = 13'd2000;
  localparam logic [12:0] BREATHE_H  = 13'd1000;
  localparam logic [12:0] BLINK_P    = 13'd600;
  localparam logic [12:0] BLINK_ON   = 13'd300;
  localparam logic [12:0] FLASH_P    = 13'd200;
  localparam logic [12:0] FLASH_ON   = 13'd100;
  localparam logic [31:0] BEEP_GAP   = 32'd2000;
  localparam logic [31:0] BEEP_LEN   = 32'd200;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_MODE     = 2'd1,
    OP_RECOVERY = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ARMED    = 3'd1,
    MODE_FLIGHT   = 3'd2,
    MODE_LANDED   = 3'd3,
    MODE_FAULT    = 3'd4,
    MODE_LOW_BATT = 3'd5,
    MODE_PYRO     = 3'd6
  } mode_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [NOW_W-1:0] now;
    logic [2:0]       mode;
    logic             en;
  } item_t;

  // what the front end hands to the state stage
  typedef struct packed {
    item_t             item;
    logic              blink_on;
    logic              flash_on;
    logic [DUTY_W-1:0] breathe;   // scaled blue breathe duty
  } front_t;

  function automatic logic [SCALE_W-1:0] pct_clamp(logic [SCALE_W-1:0] p);
    return (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

  // floor(y / 100), saturated to the duty field
  function automatic logic [DUTY_W-1:0] div100_sat(logic [22:0] y);
    logic [46:0] prod;
    logic [16:0] quo;
    prod = 47'(y) * 47'(M100);
    quo  = prod[46:K100];
    return (quo > 17'(DUTY_SAT)) ? DUTY_SAT : quo[DUTY_W-1:0];
  endfunction

endpackage

@@ hw/rtl/slbs_scale.sv @@
// ----------------------------------------------------------------------------
// slbs_scale
// Brightness trim registers and the per-channel scaled full duty.
// ----------------------------------------------------------------------------
module slbs_scale #(
  parameter int FULL_DUTY = slbs_pkg::FULL_DUTY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [slbs_pkg::CFG_W-1:0]   cfg_idx_i,
  input  logic [slbs_pkg::SCALE_W-1:0] cfg_data_i,
  output logic [slbs_pkg::SCALE_W-1:0] blue_pct_o,
  output logic [slbs_pkg::DUTY_W-1:0]  full_red_o,
  output logic [slbs_pkg::DUTY_W-1:0]  full_green_o,
  output logic [slbs_pkg::DUTY_W-1:0]  full_blue_o
);
  import slbs_pkg::*;

  localparam logic [FULL_W-1:0] FullVal = FULL_DUTY[FULL_W-1:0];

  logic [SCALE_W-1:0] scale_q [3];
  logic [22:0]        prod_q  [3];
  logic [DUTY_W-1:0]  full_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q[0] <= PCT_MAX;
      scale_q[1] <= PCT_MAX;
      scale_q[2] <= PCT_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RED:   scale_q[0] <= cfg_data_i;
        CFG_GREEN: scale_q[1] <= cfg_data_i;
        CFG_BLUE:  scale_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // after a write the duties settle through prod_q and full_q; items take longer to reach the user
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= 23'(FullVal) * 23'(pct_clamp(scale_q[c]));
      full_q[c] <= div100_sat(prod_q[c]);
    end
  end

  assign blue_pct_o   = pct_clamp(scale_q[2]);
  assign full_red_o   = full_q[0];
  assign full_green_o = full_q[1];
  assign full_blue_o  = full_q[2];

endmodule

@@ hw/rtl/slbs_front.sv @@
// ----------------------------------------------------------------------------
// slbs_front
// Input register and the state-free time pipeline: time residues, blink and
// flash phases, and the scaled blue breathe duty.
// ----------------------------------------------------------------------------
module slbs_front #(
  parameter int FULL_DUTY = slbs_pkg::FULL_DUTY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  slbs_pkg::item_t              in_item_i,
  input  logic [slbs_pkg::SCALE_W-1:0] blue_pct_i,
  output logic                         fr_valid_o,
  input  logic                         fr_ready_i,
  output slbs_pkg::front_t             fr_data_o
);
  import slbs_pkg::*;

  localparam int NST = 7;
  localparam logic [FULL_W-1:0] FullVal = FULL_DUTY[FULL_W-1:0];

  logic [NST-1:0] vld_q;
  logic [NST:0]   rdy;

  item_t       it_q [NST];
  logic [19:0] quo_q;        // (now >> 4) / 375
  logic [12:0] res_q;        // now % 6000
  logic [25:0] tprod_q;      // breathe ramp times full duty
  logic [15:0] tri_q;
  logic [22:0] bprod_q;
  logic [DUTY_W-1:0] breathe_q;
  logic [NST-1:3] blink_q, flash_q;

  // combinational logic between the stage registers
  logic [27:0] x28;
  logic [56:0] qprod;
  logic [27:0] rem28;
  logic [12:0] p2000, p600, p200;
  logic [9:0]  ramp;
  logic [52:0] tdiv;

  always_comb begin
    rdy[NST] = fr_ready_i;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_comb begin
    x28   = it_q[0].now[31:4];
    qprod = 57'(x28) * 57'(M375);
    rem28 = it_q[1].now[31:4] - 28'(29'(quo_q) * 29'(LCM_DIV));

    if (res_q >= 13'(2 * BREATHE_P))  p2000 = res_q - 13'(2 * BREATHE_P);
    else if (res_q >= BREATHE_P)      p2000 = res_q - BREATHE_P;
    else                              p2000 = res_q;
    ramp = (p2000 < BREATHE_H) ? p2000[9:0] : 10'(BREATHE_P - p2000);

    // residue less the highest multiple of 600 not above it
    p600 = res_q;
    for (int k = 1; k < 10; k++) begin
      if (res_q >= 13'(k) * BLINK_P) p600 = res_q - 13'(k) * BLINK_P;
    end
    if (p600 >= 13'(2 * FLASH_P))  p200 = p600 - 13'(2 * FLASH_P);
    else if (p600 >= FLASH_P)      p200 = p600 - FLASH_P;
    else                           p200 = p600;

    tdiv = 53'(tprod_q) * 53'(M1000);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) it_q[0] <= in_item_i;
    if (rdy[1]) begin
      it_q[1] <= it_q[0];
      quo_q   <= qprod[56:K375];
    end
    if (rdy[2]) begin
      it_q[2] <= it_q[1];
      res_q   <= {rem28[8:0], it_q[1].now[3:0]};
    end
    if (rdy[3]) begin
      it_q[3]    <= it_q[2];
      blink_q[3] <= (p600 < BLINK_ON);
      flash_q[3] <= (p200 < FLASH_ON);
    end
    if (rdy[3]) begin
      tprod_q <= 26'(ramp) * 26'(FullVal);
    end
    if (rdy[4]) begin
      it_q[4]    <= it_q[3];
      blink_q[4] <= blink_q[3];
      flash_q[4] <= flash_q[3];
      tri_q      <= tdiv[51:K1000];
    end
    if (rdy[5]) begin
      it_q[5]    <= it_q[4];
      blink_q[5] <= blink_q[4];
      flash_q[5] <= flash_q[4];
      bprod_q    <= 23'(tri_q) * 23'(blue_pct_i);
    end
    if (rdy[6]) begin
      it_q[6]    <= it_q[5];
      blink_q[6] <= blink_q[5];
      flash_q[6] <= flash_q[5];
      breathe_q  <= div100_sat(bprod_q);
    end
  end

  assign fr_valid_o          = vld_q[NST-1];
  assign fr_data_o.item      = it_q[NST-1];
  assign fr_data_o.blink_on  = blink_q[NST-1];
  assign fr_data_o.flash_on  = flash_q[NST-1];
  assign fr_data_o.breathe   = breathe_q;

endmodule

@@ hw/rtl/slbs_state.sv @@
// ----------------------------------------------------------------------------
// slbs_state
// Mode and beeper state, duty selection and the result register.
// ----------------------------------------------------------------------------
module slbs_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fr_valid_i,
  output logic                        fr_ready_o,
  input  slbs_pkg::front_t            fr_data_i,
  input  logic [slbs_pkg::DUTY_W-1:0] full_red_i,
  input  logic [slbs_pkg::DUTY_W-1:0] full_green_i,
  input  logic [slbs_pkg::DUTY_W-1:0] full_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [slbs_pkg::DUTY_W-1:0] red_duty_o,
  output logic [slbs_pkg::DUTY_W-1:0] green_duty_o,
  output logic [slbs_pkg::DUTY_W-1:0] blue_duty_o,
  output logic                        buzzer_active_o
);
  import slbs_pkg::*;

  // result register doubles as the held duties and the tone flag
  logic              out_valid_q, out_valid_d;
  logic [DUTY_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic              tone_q, tone_d;
  mode_e             mode_q, mode_d;
  logic              rec_en_q, rec_en_d;
  logic              phase_on_q, phase_on_d;
  logic [NOW_W-1:0]  last_q, last_d;

  logic       fire;
  item_t      it;
  logic [NOW_W-1:0] diff;

  assign fr_ready_o = !out_valid_q || !out_stall_i;
  assign fire       = fr_valid_i && fr_ready_o;
  assign it         = fr_data_i.item;
  assign diff       = it.now - last_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    tone_d      = tone_q;
    mode_d      = mode_q;
    rec_en_d    = rec_en_q;
    phase_on_d  = phase_on_q;
    last_d      = last_q;
    if (fire) begin
      out_valid_d = 1'b1;
      unique case (op_e'(it.op))
        OP_TICK: begin
          red_d   = '0;
          green_d = '0;
          blue_d  = '0;
          unique case (mode_q)
            MODE_IDLE:     green_d = full_green_i;
            MODE_ARMED:    blue_d  = fr_data_i.breathe;
            MODE_FLIGHT: begin
              red_d  = full_red_i;
              blue_d = full_blue_i;
            end
            MODE_LANDED: begin
              green_d = full_green_i;
              blue_d  = full_blue_i;
            end
            MODE_FAULT:    red_d = full_red_i;
            MODE_LOW_BATT: red_d = fr_data_i.blink_on ? full_red_i : '0;
            MODE_PYRO: begin
              if (fr_data_i.flash_on) begin
                red_d   = full_red_i;
                green_d = full_green_i;
                blue_d  = full_blue_i;
              end
            end
            default: ;
          endcase
          if (rec_en_q) begin
            if (!phase_on_q && diff >= BEEP_GAP) begin
              tone_d     = 1'b1;
              phase_on_d = 1'b1;
              last_d     = it.now;
            end else if (phase_on_q && diff >= BEEP_LEN) begin
              tone_d     = 1'b0;
              phase_on_d = 1'b0;
              last_d     = it.now;
            end
          end
        end
        OP_MODE: begin
          // undefined code and same mode are ignored
          if (it.mode <= MODE_PYRO && it.mode != mode_q) begin
            if (it.mode == MODE_ARMED)     tone_d = 1'b1;
            else if (mode_q == MODE_ARMED) tone_d = 1'b0;
            mode_d = mode_e'(it.mode);
          end
        end
        OP_RECOVERY: begin
          rec_en_d = it.en;
          if (!it.en) tone_d = 1'b0;
        end
        OP_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      tone_q      <= 1'b0;
      mode_q      <= MODE_IDLE;
      rec_en_q    <= 1'b0;
      phase_on_q  <= 1'b0;
      last_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      tone_q      <= tone_d;
      mode_q      <= mode_d;
      rec_en_q    <= rec_en_d;
      phase_on_q  <= phase_on_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_duty_o      = red_q;
  assign green_duty_o    = green_q;
  assign blue_duty_o     = blue_q;
  assign buzzer_active_o = tone_q;

endmodule

@@ hw/rtl/status_light_and_beeper_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// status_light_and_beeper_sequencer_core
// RGB indication and locator-beep sequencer driven by ticks and events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per event: a
//   millisecond tick (now_ms_i), a mode change (mode_i) or a recovery beep
//   enable (enable_i), selected by operation_i. Every word yields exactly one
//   result word on the output channel (out_valid_o / out_stall_i): the held,
//   trimmed RGB duties and the buzzer flag.
//   Trim registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle; trims above 100 act as 100. The scaled full
//   duties settle after a write, through a product and a full-duty register.
//   Path: a taken word passes seven front stages working out time residues
//   and the breathe ramp, the first of them loaded at the taking edge,
//   then the state stage and result register.
//   Throughput: one word per cycle while out_stall_i is low; set by the state
//   stage, which updates mode, beep phase and held duties once per word.
//   Reset: trims return to 100, mode to idle, duties and buzzer to zero, the
//   pipeline empties. No clearing pass is needed.
//   Receiver stall: the result register holds; the front keeps taking words
//   until all its stages are full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module status_light_and_beeper_sequencer_core #(
  parameter int FULL_DUTY = slbs_pkg::FULL_DUTY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [slbs_pkg::NOW_W-1:0]   now_ms_i,
  input  logic [2:0]                   mode_i,
  input  logic                         enable_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [slbs_pkg::DUTY_W-1:0]  red_duty_o,
  output logic [slbs_pkg::DUTY_W-1:0]  green_duty_o,
  output logic [slbs_pkg::DUTY_W-1:0]  blue_duty_o,
  output logic                         buzzer_active_o,
  input  logic                         cfg_we_i,
  input  logic [slbs_pkg::CFG_W-1:0]   cfg_idx_i,
  input  logic [slbs_pkg::SCALE_W-1:0] cfg_data_i
);
  import slbs_pkg::*;

  item_t              in_item;
  front_t             fr_data;
  logic               fr_valid, fr_ready;
  logic [SCALE_W-1:0] blue_pct;
  logic [DUTY_W-1:0]  full_red, full_green, full_blue;

  assign in_item.op   = operation_i;
  assign in_item.now  = now_ms_i;
  assign in_item.mode = mode_i;
  assign in_item.en   = enable_i;

  // trims and their scaled full-on duty per channel
  slbs_scale #(.FULL_DUTY(FULL_DUTY)) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .blue_pct_o   (blue_pct),
    .full_red_o   (full_red),
    .full_green_o (full_green),
    .full_blue_o  (full_blue)
  );

  // time-only work: no dependence on mode or beep state
  slbs_front #(.FULL_DUTY(FULL_DUTY)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .blue_pct_i (blue_pct),
    .fr_valid_o (fr_valid),
    .fr_ready_i (fr_ready),
    .fr_data_o  (fr_data)
  );

  // per-word state update and result register
  slbs_state u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fr_valid_i      (fr_valid),
    .fr_ready_o      (fr_ready),
    .fr_data_i       (fr_data),
    .full_red_i      (full_red),
    .full_green_i    (full_green),
    .full_blue_i     (full_blue),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_duty_o      (red_duty_o),
    .green_duty_o    (green_duty_o),
    .blue_duty_o     (blue_duty_o),
    .buzzer_active_o (buzzer_active_o)
  );

endmodule

@@ hw/rtl/slbs_checker.sv @@
// ----------------------------------------------------------------------------
// slbs_checker
// Port-level checks for the sequencer core, bound to the top level.
// ----------------------------------------------------------------------------
module slbs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [slbs_pkg::DUTY_W-1:0]  red_duty_o,
  input logic [slbs_pkg::DUTY_W-1:0]  green_duty_o,
  input logic [slbs_pkg::DUTY_W-1:0]  blue_duty_o,
  input logic                         buzzer_active_o
);

  // an empty result register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result side can move");

  // a result only leaves when it was taken
  a_leave_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without being taken");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("out_valid_o fell under stall");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(red_duty_o) && $stable(green_duty_o)
      && $stable(blue_duty_o) && $stable(buzzer_active_o)))
    else $error("result changed under stall");

endmodule

bind status_light_and_beeper_sequencer_core slbs_checker u_slbs_checker (.*);

@@ verif/status_light_and_beeper_sequencer_core_test.sv @@
// ----------------------------------------------------------------------------
// status_light_and_beeper_sequencer_core_test
// Self-checking bench for the status light and beeper sequencer. A directed
// table walks reset values, every mode, the blink/flash edges, the beep
// cycle and its wrapping time difference. Random phases follow, each under
// its own trim setting. Every accepted word is run through a local lamp and
// beeper model. Every result word is compared field by field against the
// oldest prediction. Sender bursts and receiver stalls are random, and one
// long receiver hold fills the pipeline.
// ----------------------------------------------------------------------------
module status_light_and_beeper_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slbs_pkg::*;

  localparam int FULL        = FULL_DUTY_DEF;
  localparam int LIMIT       = 400000;   // cycles, far above a slow clean run
  localparam int IDLE_PAUSE  = 12;       // covers the pipeline latency
  localparam int DRAIN_EXTRA = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 200;
  localparam int HOLD_CYCLES = 150;

  localparam logic [2:0]       MODE_UNDEF = 3'd7;
  localparam logic [CFG_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
    logic              buzz;
  } lamp_word_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [NOW_W-1:0] now;
    logic [2:0]       mode;
    logic             en;
    logic             typed;   // want holds a hand-written result
    lamp_word_t       want;
  } drill_row_t;

  localparam lamp_word_t NO_WANT = '0;

  localparam drill_row_t DRILL_ROWS [0:27] = '{
    // unused code right after reset: everything still zero
    '{OP_NONE,     32'hFFFF_FFFF, MODE_UNDEF,    1'b1, 1'b1, '{10'd0, 10'd0, 10'd0, 1'b0}},
    '{OP_TICK,     32'd0,         MODE_IDLE,     1'b0, 1'b1, '{10'd0, 10'd1000, 10'd0, 1'b0}},
    // undefined mode, then the held mode again: no change
    '{OP_MODE,     32'd0,         MODE_UNDEF,    1'b0, 1'b1, '{10'd0, 10'd1000, 10'd0, 1'b0}},
    '{OP_MODE,     32'd0,         MODE_IDLE,     1'b0, 1'b1, '{10'd0, 10'd1000, 10'd0, 1'b0}},
    '{OP_MODE,     32'd0,         MODE_ARMED,    1'b0, 1'b1, '{10'd0, 10'd1000, 10'd0, 1'b1}},
    '{OP_TICK,     32'd500,       MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'hFFFF_FFFF, MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_MODE,     32'd0,         MODE_FLIGHT,   1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd1234,      MODE_IDLE,     1'b0, 1'b1, '{10'd1000, 10'd0, 10'd1000, 1'b0}},
    '{OP_MODE,     32'd0,         MODE_LANDED,   1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd77,        MODE_IDLE,     1'b0, 1'b1, '{10'd0, 10'd1000, 10'd1000, 1'b0}},
    '{OP_MODE,     32'd0,         MODE_FAULT,    1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd5,         MODE_IDLE,     1'b0, 1'b1, '{10'd1000, 10'd0, 10'd0, 1'b0}},
    // blink and flash on/off edges
    '{OP_MODE,     32'd0,         MODE_LOW_BATT, 1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd299,       MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd300,       MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_MODE,     32'd0,         MODE_PYRO,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd99,        MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd100,       MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    // enable only arms the pattern; beep starts 2000 ms after last change
    '{OP_RECOVERY, 32'd0,         MODE_IDLE,     1'b1, 1'b0, NO_WANT},
    '{OP_TICK,     32'd1999,      MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd2000,      MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd2200,      MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    // disable stops the tone even while armed
    '{OP_MODE,     32'd0,         MODE_ARMED,    1'b0, 1'b0, NO_WANT},
    '{OP_RECOVERY, 32'd0,         MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_RECOVERY, 32'd0,         MODE_IDLE,     1'b1, 1'b0, NO_WANT},
    // beep on near the top of time, off after the wrap
    '{OP_TICK,     32'hFFFF_FF00, MODE_IDLE,     1'b0, 1'b0, NO_WANT},
    '{OP_TICK,     32'd100,       MODE_IDLE,     1'b0, 1'b0, NO_WANT}
  };

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_COIN,
    STALL_HOLD
  } stall_kind_e;

  // DUT signals, all known from time zero
  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i     = OP_TICK;
  logic [NOW_W-1:0]  now_ms_i        = '0;
  logic [2:0]        mode_i          = MODE_IDLE;
  logic              enable_i        = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [DUTY_W-1:0] red_duty_o;
  logic [DUTY_W-1:0] green_duty_o;
  logic [DUTY_W-1:0] blue_duty_o;
  logic              buzzer_active_o;
  logic              cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]  cfg_idx_i       = CFG_RED;
  logic [SCALE_W-1:0] cfg_data_i     = '0;

  // lamp/beeper model state, reset values
  logic [SCALE_W-1:0] red_trim       = 7'd100;
  logic [SCALE_W-1:0] green_trim     = 7'd100;
  logic [SCALE_W-1:0] blue_trim      = 7'd100;
  logic [2:0]         lamp_mode      = MODE_IDLE;
  logic               beep_enabled   = 1'b0;
  logic               beep_on        = 1'b0;
  logic [NOW_W-1:0]   phase_start_ms = '0;
  logic               tone_on        = 1'b0;
  logic [DUTY_W-1:0]  held_red       = '0;
  logic [DUTY_W-1:0]  held_green     = '0;
  logic [DUTY_W-1:0]  held_blue      = '0;

  lamp_word_t expected_words [$];
  int         fails        = 0;
  int         cycle_count  = 0;
  int         holds_asked  = 0;
  int         holds_done   = 0;
  logic [NOW_W-1:0] tick_ms = '0;   // running clock for well-formed tick runs

  status_light_and_beeper_sequencer_core #(
    .FULL_DUTY(FULL)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .now_ms_i       (now_ms_i),
    .mode_i         (mode_i),
    .enable_i       (enable_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_duty_o     (red_duty_o),
    .green_duty_o   (green_duty_o),
    .blue_duty_o    (blue_duty_o),
    .buzzer_active_o(buzzer_active_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // percent trim, clamped at 100, saturated to the duty field
  function automatic logic [DUTY_W-1:0] trim_duty(int unsigned duty, logic [SCALE_W-1:0] pct);
    longint unsigned p;
    longint unsigned v;
    p = (pct > 7'd100) ? 100 : pct;
    v = (longint'(duty) * p) / 100;
    if (v > 1023) v = 1023;
    return DUTY_W'(v);
  endfunction

  // blue breathe: triangle over 2000 ms, peak at 1000 ms
  function automatic int unsigned breathe_level(logic [NOW_W-1:0] now);
    int unsigned p;
    int unsigned v;
    p = now % 32'd2000;
    v = (p < 1000) ? p : 2000 - p;
    return (v * FULL) / 1000;
  endfunction

  // advances the lamp/beeper state by one word, returns the result word
  function automatic lamp_word_t advance_lamps(logic [1:0] op, logic [NOW_W-1:0] now,
                                               logic [2:0] m, logic en);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic [NOW_W-1:0] since;
    lamp_word_t w;
    r = 0;
    g = 0;
    b = 0;
    case (op)
      OP_TICK: begin
        case (lamp_mode)
          MODE_IDLE:     g = FULL;
          MODE_ARMED:    b = breathe_level(now);
          MODE_FLIGHT: begin
            r = FULL;
            b = FULL;
          end
          MODE_LANDED: begin
            g = FULL;
            b = FULL;
          end
          MODE_FAULT:    r = FULL;
          MODE_LOW_BATT: r = ((now % 32'd600) < 300) ? FULL : 0;
          default: begin
            if ((now % 32'd200) < 100) begin
              r = FULL;
              g = FULL;
              b = FULL;
            end
          end
        endcase
        held_red   = trim_duty(r, red_trim);
        held_green = trim_duty(g, green_trim);
        held_blue  = trim_duty(b, blue_trim);
        if (beep_enabled) begin
          since = now - phase_start_ms;   // wraps mod 2^32
          if (!beep_on && since >= 32'd2000) begin
            tone_on        = 1'b1;
            beep_on        = 1'b1;
            phase_start_ms = now;
          end else if (beep_on && since >= 32'd200) begin
            tone_on        = 1'b0;
            beep_on        = 1'b0;
            phase_start_ms = now;
          end
        end
      end
      OP_MODE: begin
        if (m <= MODE_PYRO && m != lamp_mode) begin
          if (m == MODE_ARMED) tone_on = 1'b1;
          else if (lamp_mode == MODE_ARMED) tone_on = 1'b0;
          lamp_mode = m;
        end
      end
      OP_RECOVERY: begin
        beep_enabled = en;
        if (!en) tone_on = 1'b0;
      end
      default: ;
    endcase
    w.red   = held_red;
    w.green = held_green;
    w.blue  = held_blue;
    w.buzz  = tone_on;
    return w;
  endfunction

  // offer one word, hold it until taken, then log what it should produce
  task automatic send_word(input logic [1:0] op, input logic [NOW_W-1:0] now,
                           input logic [2:0] m, input logic en,
                           input logic typed, input lamp_word_t want);
    lamp_word_t predicted;
    @(negedge clk_i) begin
      in_valid_i  <= 1'b1;
      operation_i <= op;
      now_ms_i    <= now;
      mode_i      <= m;
      enable_i    <= en;
    end
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = advance_lamps(op, now, m, en);
    expected_words.push_back(typed ? want : predicted);
  endtask

  // trims change only with the pipeline empty
  task automatic set_trims(input logic [SCALE_W-1:0] r, input logic [SCALE_W-1:0] g,
                           input logic [SCALE_W-1:0] b);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(negedge clk_i);
    @(negedge clk_i) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_RED;
      cfg_data_i <= r;
    end
    @(negedge clk_i) begin
      cfg_idx_i  <= CFG_GREEN;
      cfg_data_i <= g;
    end
    @(negedge clk_i) begin
      cfg_idx_i  <= CFG_BLUE;
      cfg_data_i <= b;
    end
    // no register behind index 3: must be ignored
    @(negedge clk_i) begin
      cfg_idx_i  <= CFG_UNUSED;
      cfg_data_i <= SCALE_W'($urandom);
    end
    @(negedge clk_i) cfg_we_i <= 1'b0;
    repeat (IDLE_PAUSE) @(negedge clk_i);   // scaled duties settle
    red_trim   = r;
    green_trim = g;
    blue_trim  = b;
  endtask

  // receiver: stall segments of random kind and length, plus requested holds
  always begin : stall_pattern
    stall_kind_e kind;
    int len;
    int k;
    kind = stall_kind_e'($urandom_range(STALL_NONE, STALL_COIN));
    len  = $urandom_range(1, 40);
    if (holds_done < holds_asked) begin
      kind = STALL_HOLD;
      len  = HOLD_CYCLES;
      holds_done++;
    end
    for (k = 0; k < len; k++) begin
      @(negedge clk_i);
      case (kind)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_SPARSE:   out_stall_i <= ($urandom_range(0, 5) == 0);
        STALL_PERIODIC: out_stall_i <= ((k % 4) != 0);
        STALL_COIN:     out_stall_i <= 1'($urandom_range(0, 1));
        default:        out_stall_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    lamp_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with no prediction pending");
        fails++;
      end else begin
        want = expected_words.pop_front();
        if (red_duty_o !== want.red) begin
          $error("red_duty expected %0d got %0d", want.red, red_duty_o);
          fails++;
        end
        if (green_duty_o !== want.green) begin
          $error("green_duty expected %0d got %0d", want.green, green_duty_o);
          fails++;
        end
        if (blue_duty_o !== want.blue) begin
          $error("blue_duty expected %0d got %0d", want.blue, blue_duty_o);
          fails++;
        end
        if (buzzer_active_o !== want.buzz) begin
          $error("buzzer_active expected %0d got %0d", want.buzz, buzzer_active_o);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int left;
    int burst;
    int gap;
    int pick;
    logic [1:0]       op;
    logic [NOW_W-1:0] now;
    logic [2:0]       m;
    logic             en;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (DRILL_ROWS[i])
      send_word(DRILL_ROWS[i].op, DRILL_ROWS[i].now, DRILL_ROWS[i].mode, DRILL_ROWS[i].en,
                DRILL_ROWS[i].typed, DRILL_ROWS[i].want);

    tick_ms = 32'd5000;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_trims(7'd0, 7'd0, 7'd0);
        1: set_trims(7'd127, 7'd127, 7'd127);
        2: set_trims(7'd100, 7'd100, 7'd100);
        3: set_trims(7'd1, 7'd50, 7'd99);
        4: set_trims(7'd101, 7'd0, 7'd100);
        default: set_trims(SCALE_W'($urandom_range(0, 127)), SCALE_W'($urandom_range(0, 127)),
                           SCALE_W'($urandom_range(0, 127)));
      endcase
      if (phase == 2) holds_asked++;               // long receiver hold-off
      if (phase == 3) tick_ms = 32'hFFFF_8000;     // run time across the wrap
      left = PHASE_WORDS;
      while (left > 0) begin
        burst = $urandom_range(1, 30);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
        while (burst > 0 && left > 0) begin
          pick = $urandom_range(0, 99);
          now  = $urandom;
          m    = 3'($urandom_range(0, 7));
          en   = 1'($urandom_range(0, 1));
          if (pick < 68) begin
            op = OP_TICK;
            if (pick < 2) begin
              tick_ms = now;                        // jump anywhere in time
            end else if ($urandom_range(0, 9) == 0) begin
              tick_ms = tick_ms + $urandom_range(0, 70000);
            end else begin
              tick_ms = tick_ms + $urandom_range(1, 250);
            end
            now = tick_ms;
          end else if (pick < 82) begin
            op = OP_MODE;
          end else if (pick < 92) begin
            op = OP_RECOVERY;
          end else begin
            op = OP_NONE;
          end
          send_word(op, now, m, en, 1'b0, NO_WANT);
          burst--;
          left--;
        end
      end
    end

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_EXTRA) @(posedge clk_i);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
